### hw/rtl/sincos_encoder_angle_speed_macros.svh
// Assertion macros shared by the encoder angle and speed block.
`ifndef SINCOS_ENCODER_ANGLE_SPEED_MACROS_SVH
`define SINCOS_ENCODER_ANGLE_SPEED_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SCE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SCE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/sce_pkg.sv
// Types, constants and tables of the encoder angle and speed block.
package sce_pkg;

    localparam int SAMPLE_BITS   = 12;
    localparam int ANGLE_BITS    = 16;
    localparam int CORDIC_STAGES = 16;

    // fixed formats
    localparam int SCALE_BITS  = 24;
    localparam int SPEED_BITS  = 32;
    localparam int SPEED_SHIFT = 8;
    localparam int FRAC_BITS   = 16;
    localparam int TURN_BITS   = 32;
    localparam int MAX_STAGES  = 24;

    // centred sample, CORDIC datapath (gain 1.65 times sqrt 2 needs 3 bits more)
    localparam int CSAMP_W  = SAMPLE_BITS + 1;
    localparam int CORDIC_W = SAMPLE_BITS + 4 + FRAC_BITS;
    localparam int STAGE_W  = $clog2(CORDIC_STAGES);
    localparam int PROD_W   = ANGLE_BITS + SCALE_BITS + 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = SCALE_BITS;

    localparam logic [TURN_BITS-1:0] HALF_TURN  = TURN_BITS'(1) << (TURN_BITS - 1);
    localparam logic [TURN_BITS-1:0] ROUND_HALF = TURN_BITS'(1) << (TURN_BITS - 1 - ANGLE_BITS);

    // atan(2^-i) in units of 2^-32 turn
    localparam logic [TURN_BITS-1:0] ATAN_TURN [0:MAX_STAGES-1] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10680862,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CENTER_CODE = 2'd0,
        REG_CLAMP_LIMIT = 2'd1,
        REG_SPEED_SCALE = 2'd2
    } sce_reg_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sine_sample;
        logic [SAMPLE_BITS-1:0] cosine_sample;
    } sce_sample_t;

    typedef struct packed {
        logic [ANGLE_BITS-1:0]        angle;
        logic signed [SPEED_BITS-1:0] speed;
        logic                         speed_valid;
    } sce_result_t;

    // vector travelling down the CORDIC chain
    typedef struct packed {
        logic                       zero;
        logic signed [CORDIC_W-1:0] x;
        logic signed [CORDIC_W-1:0] y;
        logic [TURN_BITS-1:0]       z;
    } sce_vec_t;

    // pipeline control handed to every stage
    typedef struct packed {
        logic adv;
        logic vld;
    } sce_ctl_t;

endpackage

### hw/rtl/sincos_encoder_angle_speed.sv
// Top level of the sine/cosine encoder angle and speed block.
// Takes one sine/cosine sample pair per cycle and returns one angle and speed
// item per pair, in order. The pipeline registers, in order, are centring and
// clamping, one per CORDIC micro-rotation cell, angle rounding and the
// delta-times-scale multiply. Throughput is one item per clock; a stall on the
// result side holds the whole pipeline, and the sample side is stalled only
// while the result register is full and held.
// Speed history advances only on items whose speed_scale was nonzero, so
// configuration should be written while the pipeline is empty.
`include "sincos_encoder_angle_speed_macros.svh"

module sincos_encoder_angle_speed (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              sample_valid,
    output logic                              sample_stall,
    input  sce_pkg::sce_sample_t              sample_item,
    output logic                              result_valid,
    input  logic                              result_stall,
    output sce_pkg::sce_result_t              result_item,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sce_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sce_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import sce_pkg::*;

    logic [SAMPLE_BITS-1:0] center_code_reg;
    logic [SAMPLE_BITS-1:0] clamp_limit_reg;
    logic [SCALE_BITS-1:0]  speed_scale_reg;
    logic                   adv;
    sce_ctl_t               front_ctl;
    logic                   chain_vld [CORDIC_STAGES+1];
    sce_vec_t               chain_vec [CORDIC_STAGES+1];
    sce_ctl_t               speed_ctl;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_code_reg <= SAMPLE_BITS'(508);
            clamp_limit_reg <= SAMPLE_BITS'(380);
            speed_scale_reg <= SCALE_BITS'(62832);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_CENTER_CODE: center_code_reg <= cfg_data[SAMPLE_BITS-1:0];
                REG_CLAMP_LIMIT: clamp_limit_reg <= cfg_data[SAMPLE_BITS-1:0];
                REG_SPEED_SCALE: speed_scale_reg <= cfg_data[SCALE_BITS-1:0];
                default: ;
            endcase
        end
    end

    // whole pipeline moves unless a finished item is held at the output
    assign adv          = !(result_valid && result_stall);
    assign sample_stall = !adv;

    assign front_ctl.adv = adv;
    assign front_ctl.vld = sample_valid;

    sce_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (front_ctl),
        .item        (sample_item),
        .center_code (center_code_reg),
        .clamp_limit (clamp_limit_reg),
        .out_vld     (chain_vld[0]),
        .out_vec     (chain_vec[0])
    );

    // CORDIC micro-rotation chain
    for (genvar g = 0; g < CORDIC_STAGES; g++)
    begin : g_cell
        sce_ctl_t cell_ctl;

        assign cell_ctl.adv = adv;
        assign cell_ctl.vld = chain_vld[g];

        sce_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (cell_ctl),
            .in_vec     (chain_vec[g]),
            .shift      (STAGE_W'(g)),
            .step_angle (ATAN_TURN[g]),
            .out_vld    (chain_vld[g+1]),
            .out_vec    (chain_vec[g+1])
        );
    end

    assign speed_ctl.adv = adv;
    assign speed_ctl.vld = chain_vld[CORDIC_STAGES];

    sce_speed u_speed (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (speed_ctl),
        .in_vec      (chain_vec[CORDIC_STAGES]),
        .speed_scale (speed_scale_reg),
        .out_vld     (result_valid),
        .out_item    (result_item)
    );

    // checks
    `SCE_ASSERT_NOW(a_stall_only_when_full, clk, rst_n, sample_stall, result_valid && result_stall, "sample side stalled without a held result")
    `SCE_ASSERT_NOW(a_invalid_speed_zero, clk, rst_n, result_valid && !result_item.speed_valid, result_item.speed == '0, "invalid speed is not zero")
    `SCE_ASSERT_NOW(a_valid_needs_scale, clk, rst_n, result_valid && result_item.speed_valid, speed_scale_reg != '0, "valid speed with zero scale")

endmodule

### hw/rtl/sce_front.sv
// Input stage: centre and clamp both samples, fold the left half plane.
module sce_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  sce_pkg::sce_ctl_t          ctl,
    input  sce_pkg::sce_sample_t       item,
    input  logic [sce_pkg::SAMPLE_BITS-1:0] center_code,
    input  logic [sce_pkg::SAMPLE_BITS-1:0] clamp_limit,
    output logic                       out_vld,
    output sce_pkg::sce_vec_t          out_vec
);
    import sce_pkg::*;

    logic signed [CSAMP_W-1:0] lim;
    logic signed [CSAMP_W-1:0] nlim;
    logic signed [CSAMP_W-1:0] s_raw;
    logic signed [CSAMP_W-1:0] c_raw;
    logic signed [CSAMP_W-1:0] s_cl;
    logic signed [CSAMP_W-1:0] c_cl;
    logic signed [CORDIC_W-1:0] x_wide;
    logic signed [CORDIC_W-1:0] y_wide;
    logic                      vld_reg;
    sce_vec_t                  vec_reg;
    sce_vec_t                  vec_next;

    // centre, then clamp to plus or minus the limit
    always_comb
    begin
        lim   = $signed({1'b0, clamp_limit});
        nlim  = -lim;
        s_raw = $signed({1'b0, item.sine_sample}) - $signed({1'b0, center_code});
        c_raw = $signed({1'b0, item.cosine_sample}) - $signed({1'b0, center_code});
        s_cl  = s_raw;
        c_cl  = c_raw;
        if (s_cl > lim)
        begin
            s_cl = lim;
        end
        if (s_cl < nlim)
        begin
            s_cl = nlim;
        end
        if (c_cl > lim)
        begin
            c_cl = lim;
        end
        if (c_cl < nlim)
        begin
            c_cl = nlim;
        end
    end

    // scale to the CORDIC format; negative cosine turns by half a turn
    always_comb
    begin
        x_wide = CORDIC_W'(c_cl) <<< FRAC_BITS;
        y_wide = CORDIC_W'(s_cl) <<< FRAC_BITS;
        vec_next.zero = (s_cl == '0) && (c_cl == '0);
        if (c_cl < 0)
        begin
            vec_next.x = -x_wide;
            vec_next.y = -y_wide;
            vec_next.z = HALF_TURN;
        end
        else
        begin
            vec_next.x = x_wide;
            vec_next.y = y_wide;
            vec_next.z = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (ctl.adv)
        begin
            vld_reg <= ctl.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.adv)
        begin
            vec_reg <= vec_next;
        end
    end

    assign out_vld = vld_reg;
    assign out_vec = vec_reg;

endmodule

### hw/rtl/sce_cell.sv
// One CORDIC vectoring micro-rotation, registered.
module sce_cell (
    input  logic                         clk,
    input  logic                         rst_n,
    input  sce_pkg::sce_ctl_t            ctl,
    input  sce_pkg::sce_vec_t            in_vec,
    input  logic [sce_pkg::STAGE_W-1:0]  shift,
    input  logic [sce_pkg::TURN_BITS-1:0] step_angle,
    output logic                         out_vld,
    output sce_pkg::sce_vec_t            out_vec
);
    import sce_pkg::*;

    logic signed [CORDIC_W-1:0] xs;
    logic signed [CORDIC_W-1:0] ys;
    logic                       vld_reg;
    sce_vec_t                   vec_reg;
    sce_vec_t                   vec_next;

    // rotate toward the x axis by the sign of y
    always_comb
    begin
        xs = in_vec.x >>> shift;
        ys = in_vec.y >>> shift;
        vec_next.zero = in_vec.zero;
        if (!in_vec.y[CORDIC_W-1])
        begin
            vec_next.x = in_vec.x + ys;
            vec_next.y = in_vec.y - xs;
            vec_next.z = in_vec.z + step_angle;
        end
        else
        begin
            vec_next.x = in_vec.x - ys;
            vec_next.y = in_vec.y + xs;
            vec_next.z = in_vec.z - step_angle;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (ctl.adv)
        begin
            vld_reg <= ctl.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.adv)
        begin
            vec_reg <= vec_next;
        end
    end

    assign out_vld = vld_reg;
    assign out_vec = vec_reg;

endmodule

### hw/rtl/sce_speed.sv
// Angle rounding, wrapped difference to the last angle and speed product.
module sce_speed (
    input  logic                            clk,
    input  logic                            rst_n,
    input  sce_pkg::sce_ctl_t               ctl,
    input  sce_pkg::sce_vec_t               in_vec,
    input  logic [sce_pkg::SCALE_BITS-1:0]  speed_scale,
    output logic                            out_vld,
    output sce_pkg::sce_result_t            out_item
);
    import sce_pkg::*;

    logic [TURN_BITS-1:0]         z_round;
    logic [ANGLE_BITS-1:0]        ang_next;
    logic [ANGLE_BITS-1:0]        ang_reg;
    logic                         ang_vld_reg;
    logic [ANGLE_BITS-1:0]        prev_angle_reg;
    logic                         have_prev_reg;
    logic signed [ANGLE_BITS-1:0] delta;
    logic signed [PROD_W-1:0]     prod;
    logic                         scale_ok;
    logic                         res_vld_reg;
    sce_result_t                  res_reg;
    sce_result_t                  res_next;

    // round the turn accumulator to the output angle
    always_comb
    begin
        z_round  = in_vec.z + ROUND_HALF;
        ang_next = in_vec.zero ? '0 : z_round[TURN_BITS-1 -: ANGLE_BITS];
    end

    // delta wraps to half a turn either way by plain modular subtraction
    always_comb
    begin
        scale_ok = (speed_scale != '0);
        delta    = $signed(ang_reg - prev_angle_reg);
        prod     = PROD_W'(delta) * $signed({1'b0, speed_scale});
        res_next.angle = ang_reg;
        if (scale_ok && have_prev_reg)
        begin
            res_next.speed       = SPEED_BITS'(prod >>> SPEED_SHIFT);
            res_next.speed_valid = 1'b1;
        end
        else
        begin
            res_next.speed       = '0;
            res_next.speed_valid = 1'b0;
        end
    end

    // control and history
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ang_vld_reg    <= 1'b0;
            res_vld_reg    <= 1'b0;
            prev_angle_reg <= '0;
            have_prev_reg  <= 1'b0;
        end
        else if (ctl.adv)
        begin
            ang_vld_reg <= ctl.vld;
            res_vld_reg <= ang_vld_reg;
            if (ang_vld_reg && scale_ok)
            begin
                prev_angle_reg <= ang_reg;
                have_prev_reg  <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.adv)
        begin
            ang_reg <= ang_next;
            res_reg <= res_next;
        end
    end

    assign out_vld  = res_vld_reg;
    assign out_item = res_reg;

endmodule
